/* hdl/ewh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_pkg
// Shared constants for the equal-width histogram block: field widths,
// register map, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package ewh_pkg;

   localparam int DEF_MAX_BINS     = 64;
   localparam int DEF_COUNT_WIDTH  = 24;
   localparam int DEF_SAMPLE_WIDTH = 16;

   localparam int ORIGIN_W   = 16;
   localparam int INV_W      = 24;
   localparam int BINS_W     = 7;
   localparam int INDEX_W    = 6;
   localparam int FRAC_BITS  = 16;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ORIGIN = 2'd0;
   localparam logic [1:0] REG_INV    = 2'd1;
   localparam logic [1:0] REG_BINS   = 2'd2;

   localparam logic [ORIGIN_W-1:0] ORIGIN_RST = '0;
   localparam logic [INV_W-1:0]    INV_RST    = INV_W'(65536);
   localparam logic [BINS_W-1:0]   BINS_RST   = BINS_W'(64);

endpackage

/* hdl/ewh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read and a write to the same entry in one cycle return the
// old contents.
// ----------------------------------------------------------------------------
module ewh_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/equal_width_histogram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_width_histogram
// Counts signed samples into equal-width bins held in a RAM and, on the last
// word of a set, reads every bin in use out in order and clears all counts.
// ----------------------------------------------------------------------------
// Counting: one sample word per cycle, unless held off as below; a sample's bin
//   is updated via difference, multiply, clamp/read, increment/write.
// Readout: bins are read and zeroed in order, one read in flight at a time, each
//   registered as a bin word; unused bins are then zeroed one per cycle.
// Input is held off from the last word until readout and clearing are done.
// Reset: registers take reset values, then the RAM is cleared entry by entry.
// ----------------------------------------------------------------------------
module equal_width_histogram #(
   parameter int MAX_BINS     = ewh_pkg::DEF_MAX_BINS,
   parameter int COUNT_WIDTH  = ewh_pkg::DEF_COUNT_WIDTH,
   parameter int SAMPLE_WIDTH = ewh_pkg::DEF_SAMPLE_WIDTH,
   parameter int REQ_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8,
   parameter int RSP_DATA_W   = ((ewh_pkg::INDEX_W + COUNT_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample word
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_DATA_W-1:0]           req_tdata,  // [0 +: SAMPLE_WIDTH] sample
   input  logic                            req_tuser,  // [0] missing
   input  logic                            req_tlast,  // last_sample
   // bin word
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [RSP_DATA_W-1:0]           rsp_tdata,  // [5:0] bin_index, then bin_count
   output logic                            rsp_tlast,  // last_bin
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ewh_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ewh_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ewh_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import ewh_pkg::*;

   localparam int ADDR_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int DIFF_W  = ((SAMPLE_WIDTH > ORIGIN_W) ? SAMPLE_WIDTH : ORIGIN_W) + 1;
   localparam int PROD_W  = DIFF_W + INV_W + 1;
   localparam int HI_W    = PROD_W - FRAC_BITS;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_DUMP  = 2'd2;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);
   localparam logic [BINS_W-1:0] MAX_BINS_V = BINS_W'(MAX_BINS);

   // configuration registers
   logic [ORIGIN_W-1:0] origin_ff, origin_in;
   logic [INV_W-1:0]    inv_ff, inv_in;
   logic [BINS_W-1:0]   bins_ff, bins_in;
   logic                csr_wr;

   // control
   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;

   // pipeline
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_count_ff, s1_last_ff;
   logic signed [DIFF_W-1:0] s1_diff_ff, s1_diff_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_count_ff, s2_last_ff;
   logic signed [PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic                     s3_valid_ff, s3_valid_in;
   logic                     s3_count_ff, s3_last_ff;
   logic [ADDR_W-1:0]        s3_addr_ff, s2_addr;

   // forwarding of the previous cycle's write
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]      fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]      out_index_ff;
   logic [COUNT_WIDTH-1:0] out_count_ff;
   logic                   out_last_ff;

   logic [BINS_W-1:0]      eff_bins, top_bin;
   logic [HI_W-1:0]        s2_hi;
   logic [COUNT_WIDTH-1:0] s3_old, s3_new;
   logic                   accept, issue, s3_write;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

   // ---------------------------------------------------------------- config
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      origin_in = origin_ff;
      inv_in    = inv_ff;
      bins_in   = bins_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_ORIGIN: origin_in = csr_pwdata[ORIGIN_W-1:0];
            REG_INV:    inv_in    = csr_pwdata[INV_W-1:0];
            REG_BINS:   bins_in   = csr_pwdata[BINS_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ORIGIN: csr_prdata = CSR_DATA_W'(origin_ff);
         REG_INV:    csr_prdata = CSR_DATA_W'(inv_ff);
         REG_BINS:   csr_prdata = CSR_DATA_W'(bins_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (bins_ff == '0) begin
         eff_bins = BINS_W'(1);
      end else if (bins_ff > MAX_BINS_V) begin
         eff_bins = MAX_BINS_V;
      end else begin
         eff_bins = bins_ff;
      end
   end
   assign top_bin = eff_bins - BINS_W'(1);

   // ---------------------------------------------------------- bin pipeline
   assign req_tready = (state_ff == ST_COUNT) && !(s1_valid_ff && s1_last_ff)
                       && !(s2_valid_ff && s2_last_ff) && !(s3_valid_ff && s3_last_ff);
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in = accept;
   assign s1_diff_in  = DIFF_W'($signed(req_tdata[SAMPLE_WIDTH-1:0]))
                        - DIFF_W'($signed(origin_ff));
   assign s2_valid_in = s1_valid_ff;
   assign s2_prod_in  = PROD_W'(s1_diff_ff) * PROD_W'($signed({1'b0, inv_ff}));
   assign s3_valid_in = s2_valid_ff;

   assign s2_hi = s2_prod_ff[PROD_W-1:FRAC_BITS];
   always_comb begin
      if (s2_prod_ff[PROD_W-1]) begin
         s2_addr = '0;
      end else if (s2_hi > HI_W'(top_bin)) begin
         s2_addr = ADDR_W'(top_bin);
      end else begin
         s2_addr = s2_hi[ADDR_W-1:0];
      end
   end

   assign s3_old   = (fwd_valid_ff && (fwd_addr_ff == s3_addr_ff)) ? fwd_data_ff : ram_rdata;
   assign s3_new   = (s3_old == '1) ? s3_old : s3_old + COUNT_WIDTH'(1);
   assign s3_write = s3_valid_ff && s3_count_ff;
   assign fwd_valid_in = s3_write;

   always_ff @(posedge clock) begin
      s1_diff_ff  <= s1_diff_in;
      s1_count_ff <= !req_tuser;
      s1_last_ff  <= req_tlast;
      s2_prod_ff  <= s2_prod_in;
      s2_count_ff <= s1_count_ff;
      s2_last_ff  <= s1_last_ff;
      s3_addr_ff  <= s2_addr;
      s3_count_ff <= s2_count_ff;
      s3_last_ff  <= s2_last_ff;
      fwd_addr_ff <= s3_addr_ff;
      fwd_data_ff <= s3_new;
   end

   // ------------------------------------------------------ readout / clear
   assign issue = (state_ff == ST_DUMP) && !rd_pend_ff && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      rd_pend_in = issue;
      rd_idx_in  = issue ? k_ff : rd_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (k_ff == LAST_ADDR) begin
               state_in = ST_COUNT;
               k_in     = '0;
            end else begin
               k_in = k_ff + ADDR_W'(1);
            end
         end
         ST_COUNT: begin
            if (s3_valid_ff && s3_last_ff) begin
               state_in = ST_DUMP;
               k_in     = '0;
            end
         end
         ST_DUMP: begin
            if (issue) begin
               if (BINS_W'(k_ff) == top_bin) begin
                  if (eff_bins == MAX_BINS_V) begin
                     state_in = ST_COUNT;
                     k_in     = '0;
                  end else begin
                     state_in = ST_CLEAR;
                     k_in     = k_ff + ADDR_W'(1);
                  end
               end else begin
                  k_in = k_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            k_in     = '0;
         end
      endcase
   end

   always_comb begin
      ram_raddr = (state_ff == ST_DUMP) ? k_ff : s2_addr;
      ram_we    = 1'b0;
      ram_waddr = k_ff;
      ram_wdata = '0;
      case (state_ff)
         ST_CLEAR: ram_we = 1'b1;
         ST_DUMP:  ram_we = issue;
         ST_COUNT: begin
            ram_we    = s3_write;
            ram_waddr = s3_addr_ff;
            ram_wdata = s3_new;
         end
         default:  ram_we = 1'b0;
      endcase
   end

   ewh_ram #(
      .WIDTH  (COUNT_WIDTH),
      .DEPTH  (MAX_BINS),
      .ADDR_W (ADDR_W)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // --------------------------------------------------------------- output
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rd_pend_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         out_index_ff <= rd_idx_ff;
         out_count_ff <= ram_rdata;
         out_last_ff  <= (BINS_W'(rd_idx_ff) == top_bin);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_count_ff, INDEX_W'(out_index_ff)});
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff    <= ORIGIN_RST;
         inv_ff       <= INV_RST;
         bins_ff      <= BINS_RST;
         state_ff     <= ST_CLEAR;
         k_ff         <= '0;
         rd_pend_ff   <= 1'b0;
         rd_idx_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         origin_ff    <= origin_in;
         inv_ff       <= inv_in;
         bins_ff      <= bins_in;
         state_ff     <= state_in;
         k_ff         <= k_in;
         rd_pend_ff   <= rd_pend_in;
         rd_idx_ff    <= rd_idx_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ------------------------------------------------------------ assertions
   a_ready_only_counting: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_COUNT))
      else $error("sample word taken outside counting");

   a_no_output_overwrite: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !out_valid_ff)
      else $error("bin word would overwrite a pending word");

   a_update_while_counting: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (state_ff == ST_COUNT))
      else $error("bin update outside counting");

   a_pipe_empty_in_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff))
      else $error("samples in flight during readout");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for equal_width_histogram. A directed script covers
// the field extremes and the corner cases: zero and oversized bin counts, a
// zero inverse width, a missing last word, and a bin-count change inside a
// set. Random sets then run under several register settings and
// back-pressure mixes. Every bin word is checked against a local histogram
// predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import ewh_pkg::*;

   localparam int NUM_BINS        = DEF_MAX_BINS;
   localparam int CNT_W           = DEF_COUNT_WIDTH;
   localparam int SMP_W           = DEF_SAMPLE_WIDTH;
   localparam int REQ_W           = ((SMP_W + 7) / 8) * 8;
   localparam int RSP_W           = ((INDEX_W + CNT_W + 7) / 8) * 8;
   localparam int SETTLE_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 30;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [1:0]        reg_sel;
      logic [31:0]       value;
      logic signed [SMP_W-1:0] sample;
      logic              miss;
      logic              lst;
      int                typed_bin;   // -1: bin comes from the predictor
   } script_row_type;

   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      logic [CNT_W-1:0]   count;
      logic               closing;
   } bin_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;   // [15:0] sample
   logic                  req_tuser = 1'b0; // [0] missing
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;        // [5:0] bin_index, [29:6] bin_count
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // histogram predictor state
   logic signed [ORIGIN_W-1:0] origin_q;
   logic [INV_W-1:0]           inv_q;
   logic [BINS_W-1:0]          bins_q;
   logic [CNT_W-1:0]           bin_tally [NUM_BINS];

   bin_word_type   pending_bins [$];
   script_row_type script [$];
   int             fail_count = 0;
   int             quiet_cycles = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             sample_span = 64;

   equal_width_histogram u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int bins_active();
      if (bins_q == 0) return 1;
      if (bins_q > NUM_BINS) return NUM_BINS;
      return int'(bins_q);
   endfunction

   function automatic int bin_for(logic signed [SMP_W-1:0] s);
      longint diff, prod, top;
      diff = longint'(s) - longint'(origin_q);
      prod = diff * longint'(inv_q);
      top  = bins_active() - 1;
      if (prod < 0) return 0;
      prod = prod >>> FRAC_BITS;
      return int'((prod > top) ? top : prod);
   endfunction

   function automatic void count_word(logic signed [SMP_W-1:0] s, logic miss, logic lst,
                                      int typed);
      int b, n;
      if (!miss) begin
         b = (typed >= 0) ? typed : bin_for(s);
         if (bin_tally[b] != '1) bin_tally[b]++;
      end
      if (lst) begin
         n = bins_active();
         for (int k = 0; k < n; k++)
            pending_bins.insert(pending_bins.size(),
                                '{INDEX_W'(k), bin_tally[k], (k == n - 1)});
         foreach (bin_tally[k]) bin_tally[k] = '0;
      end
   endfunction

   function automatic logic signed [SMP_W-1:0] next_sample();
      case ($urandom_range(3))
         0: return SMP_W'($urandom);
         1: return SMP_W'(origin_q + $urandom_range(0, sample_span));
         2: return SMP_W'(origin_q - $urandom_range(0, 8));
         default: begin
            case ($urandom_range(2))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               default: return origin_q;
            endcase
         end
      endcase
   endfunction

   function automatic void add_word(logic signed [SMP_W-1:0] s, logic miss, logic lst,
                                    int typed);
      script.insert(script.size(), '{ROW_WORD, REG_ORIGIN, 32'd0, s, miss, lst, typed});
   endfunction

   function automatic void add_reg(logic [1:0] r, logic [31:0] v);
      script.insert(script.size(), '{ROW_REG, r, v, '0, 1'b0, 1'b0, -1});
   endfunction

   task automatic send_word(logic signed [SMP_W-1:0] s, logic miss, logic lst, int typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(unsigned'(s));
      req_tuser  <= miss;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      count_word(s, miss, lst, typed);
   endtask

   // writes only once the block has drained and settled
   task automatic write_reg(logic [1:0] r, logic [31:0] v);
      req_tvalid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(r) << 2;
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (r)
         REG_ORIGIN: origin_q = v[ORIGIN_W-1:0];
         REG_INV:    inv_q    = v[INV_W-1:0];
         REG_BINS:   bins_q   = v[BINS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic build_script();
      // reset setting: unit width from zero, 64 bins
      add_word(16'sd0,      1'b0, 1'b0, 0);
      add_word(16'sd5,      1'b0, 1'b0, 5);
      add_word(-16'sd32768, 1'b0, 1'b0, 0);
      add_word(16'sd32767,  1'b0, 1'b0, 63);
      add_word(16'sd63,     1'b0, 1'b0, 63);
      add_word(16'sd64,     1'b0, 1'b0, 63);
      add_word(16'sd7,      1'b1, 1'b0, -1);
      add_word(16'sd1,      1'b0, 1'b1, 1);
      // zero bin count acts as one bin
      add_reg(REG_BINS, 32'd0);
      add_word(16'sd30,     1'b0, 1'b1, 0);
      // oversized bin count saturates; missing last word still reads out
      add_reg(REG_BINS, 32'd127);
      add_word(16'sd10,     1'b0, 1'b0, 10);
      add_word(16'sd3,      1'b1, 1'b1, -1);
      // zero inverse width
      add_reg(REG_INV, 32'd0);
      add_word(16'sd32767,  1'b0, 1'b0, 0);
      add_word(-16'sd32768, 1'b0, 1'b1, 0);
      // widest product, then bin count shrunk inside the set
      add_reg(REG_ORIGIN, 32'h0000_8000);
      add_reg(REG_INV, 32'h00FF_FFFF);
      add_reg(REG_BINS, 32'd64);
      add_word(-16'sd32768, 1'b0, 1'b0, 0);
      add_word(-16'sd32767, 1'b0, 1'b0, 63);
      add_word(16'sd32767,  1'b0, 1'b0, 63);
      add_reg(REG_BINS, 32'd8);
      add_word(-16'sd32767, 1'b0, 1'b1, 7);
      // top origin: everything below it is negative
      add_reg(REG_ORIGIN, 32'h0000_7FFF);
      add_reg(REG_INV, 32'h0002_0000);
      add_reg(REG_BINS, 32'd16);
      add_word(16'sd32767,  1'b0, 1'b0, 0);
      add_word(-16'sd32768, 1'b0, 1'b0, 0);
      add_word(16'sd0,      1'b0, 1'b1, 0);
      // quarter inverse width (bins four wide): floor and clamp
      add_reg(REG_ORIGIN, 32'd100);
      add_reg(REG_INV, 32'h0000_4000);
      add_word(16'sd100,    1'b0, 1'b0, 0);
      add_word(16'sd103,    1'b0, 1'b0, 0);
      add_word(16'sd104,    1'b0, 1'b0, 1);
      add_word(16'sd163,    1'b0, 1'b0, 15);
      add_word(16'sd200,    1'b0, 1'b1, 15);
   endtask

   task automatic pick_setting(int p);
      logic [ORIGIN_W-1:0] org;
      logic [INV_W-1:0]    inv;
      logic [BINS_W-1:0]   nb;
      int                  span;
      span = $urandom_range(1, 4096);
      case (p)
         0: begin
            org = 16'h7FFF; inv = '1; nb = 7'd1; span = 65535;
         end
         1: begin
            org = 16'h8000; inv = 24'd1; nb = '1; span = 65535;
         end
         default: begin
            org = ORIGIN_W'($urandom);
            nb  = BINS_W'($urandom_range(1, NUM_BINS));
            inv = INV_W'((int'(nb) << FRAC_BITS) / span);
            if ($urandom_range(3) == 0) inv = INV_W'($urandom);
            if ($urandom_range(5) == 0) nb = BINS_W'($urandom);
         end
      endcase
      sample_span = span;
      write_reg(REG_ORIGIN, 32'(org));
      write_reg(REG_INV, 32'(inv));
      write_reg(REG_BINS, 32'(nb));
   endtask

   task automatic run_all();
      int sent, set_len;
      origin_q = ORIGIN_RST;
      inv_q    = INV_RST;
      bins_q   = BINS_RST;
      foreach (bin_tally[k]) bin_tally[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      build_script();
      foreach (script[i]) begin
         if (script[i].kind == ROW_REG)
            write_reg(script[i].reg_sel, script[i].value);
         else
            send_word(script[i].sample, script[i].miss, script[i].lst, script[i].typed_bin);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         pick_setting(p);
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            set_len = $urandom_range(1, 16);
            for (int i = 0; i < set_len; i++) begin
               if (i == set_len / 2 && $urandom_range(7) == 0)
                  write_reg(REG_BINS, 32'($urandom_range(0, 127)));
               send_word(next_sample(), $urandom_range(9) == 0, i == set_len - 1, -1);
            end
            sent += set_len;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      bin_word_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_bins.size() == 0) begin
            $error("unexpected bin word: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = pending_bins.pop_front();
            if (rsp_tdata[INDEX_W-1:0] !== want.idx) begin
               $error("bin_index: expected %0d, got %0d", want.idx, rsp_tdata[INDEX_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[INDEX_W +: CNT_W] !== want.count) begin
               $error("bin_count: expected %0d, got %0d", want.count,
                      rsp_tdata[INDEX_W +: CNT_W]);
               fail_count++;
            end
            if (rsp_tlast !== want.closing) begin
               $error("last_bin: expected %b, got %b", want.closing, rsp_tlast);
               fail_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      fork
         run_all();
         wait (quiet_cycles >= WATCHDOG_LIMIT);
      join_any
      if (quiet_cycles >= WATCHDOG_LIMIT)
         $error("watchdog: no handshake for %0d cycles, %0d bin words outstanding",
                quiet_cycles, pending_bins.size());
      if (fail_count == 0 && quiet_cycles < WATCHDOG_LIMIT)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* sim.f */
hdl/ewh_pkg.sv
hdl/ewh_ram.sv
hdl/equal_width_histogram.sv
verif/tb_top.sv
